FILE: rtl/core/radar_frame_presence_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Radar frame presence detector assertion macros
// Concurrent checks on clk, disabled while rst_n is low. Defining NO_ASSERTIONS
// removes them.
// ----------------------------------------------------------------------------
`ifndef RADAR_FRAME_PRESENCE_DETECTOR_UNIT_ASSERT_SVH
`define RADAR_FRAME_PRESENCE_DETECTOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RFPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfpd: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define RFPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfpd: next-cycle check failed");
`else
`define RFPD_ASSERT_SAME(lbl, ante, cons)
`define RFPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/rfpd_pkg.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector package
// Frame layout constants, register indexes and the types shared by the core.
// ----------------------------------------------------------------------------
package rfpd_pkg;

  // Frame header and layout.
  localparam logic [7:0] HDR_FIRST    = 8'h55;
  localparam logic [7:0] HDR_SECOND   = 8'hA5;
  localparam logic [4:0] POS_HUNT     = 5'd0;
  localparam logic [4:0] POS_HDR2     = 5'd1;
  localparam logic [4:0] POS_BODY     = 5'd2;
  localparam logic [4:0] POS_PRESENCE = 5'd8;
  localparam logic [4:0] POS_DIST_HI  = 5'd9;
  localparam logic [4:0] POS_DIST_LO  = 5'd10;
  localparam logic [4:0] POS_SIG_HI   = 5'd15;
  localparam logic [4:0] POS_SIG_LO   = 5'd16;
  localparam logic [4:0] POS_CKSUM    = 5'd17;

  // Configuration register indexes.
  localparam logic [7:0] REG_SIG_THR     = 8'd0;
  localparam logic [7:0] REG_DIST_MIN    = 8'd1;
  localparam logic [7:0] REG_DIST_MAX    = 8'd2;
  localparam logic [7:0] REG_RUN_NEEDED  = 8'd3;

  // Register reset values.
  localparam logic [15:0] RST_SIG_THR    = 16'd150;
  localparam logic [15:0] RST_DIST_MIN   = 16'd10;
  localparam logic [15:0] RST_DIST_MAX   = 16'd150;
  localparam logic [7:0]  RST_RUN_NEEDED = 8'd3;

  // Presence codes and the motion run ceiling.
  localparam logic [7:0] PRES_NONE   = 8'd0;
  localparam logic [7:0] PRES_MOTION = 8'd1;
  localparam logic [7:0] PRES_STILL  = 8'd2;
  localparam logic [7:0] RUN_MAX     = 8'hFF;

  // Reduced threshold ratio: signal * 10 >= threshold * 7.
  localparam logic [19:0] WEAK_SIG_MUL = 20'd10;
  localparam logic [19:0] WEAK_THR_MUL = 20'd7;

  // Frame status codes.
  localparam logic FRAME_OK      = 1'b0;
  localparam logic FRAME_CKS_ERR = 1'b1;

  typedef struct packed {
    logic [15:0] signal_threshold;
    logic [15:0] distance_min;
    logic [15:0] distance_max;
    logic [7:0]  motion_run_needed;
  } cfg_t;

  // What the framer knows about the byte waiting at its input.
  typedef struct packed {
    logic        last;
    logic        cksum_ok;
    logic [7:0]  presence;
    logic [15:0] distance;
    logic [15:0] signal;
  } frame_t;

  typedef struct packed {
    logic        frame_status;
    logic [7:0]  presence_code;
    logic [15:0] target_distance;
    logic [15:0] signal_level;
    logic        in_zone;
    logic        range_changed;
    logic [7:0]  motion_run;
  } result_t;

endpackage

FILE: rtl/core/rfpd_in_if.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector byte channel
// One received serial byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/rfpd_out_if.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector result channel
// One frame result per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfpd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic [7:0]  presence_code;
  logic [15:0] target_distance;
  logic [15:0] signal_level;
  logic        in_zone;
  logic        range_changed;
  logic [7:0]  motion_run;

  modport source (
    output valid, output frame_status, output presence_code, output target_distance,
    output signal_level, output in_zone, output range_changed, output motion_run,
    input ready
  );
  modport sink (
    input valid, input frame_status, input presence_code, input target_distance,
    input signal_level, input in_zone, input range_changed, input motion_run,
    output ready
  );
endinterface

FILE: rtl/core/rfpd_cfg_if.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector configuration channel
// Register writes: index and data per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  idx;
  logic [15:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

FILE: rtl/core/radar_frame_presence_detector_unit.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector
// Frames a radar serial byte stream and reports presence decisions.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on in_ch (valid/ready, one rx_byte per word). The block looks
// for the 0x55 0xA5 header, collects an 18-byte frame and checks its additive
// checksum. The byte that ends a frame yields one word on out_ch; all other
// bytes yield nothing. cfg_ch writes the threshold, distance window and motion
// run length by index; it is always ready and must only be used while idle.
// An accepted byte is held in an input register and then handled; a frame
// result is held in a result register and stays on out_ch until it is taken.
// One byte per cycle is sustained unless a frame-ending byte waits: it stays
// in the input register while the result register is still full and
// out_ch.ready is low. Other bytes keep flowing while a result waits.
// Reset (synchronous, rst_n low) returns to the header hunt, clears the motion
// run and previous decision, empties both registers and restores the default
// configuration.
// ----------------------------------------------------------------------------
`include "radar_frame_presence_detector_unit_assert.svh"

module radar_frame_presence_detector_unit (
  input  logic       clk,
  input  logic       rst_n,
  rfpd_in_if.sink    in_ch,
  rfpd_out_if.source out_ch,
  rfpd_cfg_if.sink   cfg_ch
);
  import rfpd_pkg::*;

  logic       byte_valid_r;
  logic [7:0] byte_r;
  logic       out_valid_r;
  result_t    result_r;
  logic       step;
  logic       in_take;
  cfg_t       cfg;
  frame_t     frm;
  result_t    res;

  rfpd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rfpd_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .frm     (frm)
  );

  rfpd_decider u_decider (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .frm   (frm),
    .cfg   (cfg),
    .res   (res)
  );

  // The held byte moves on unless it ends a frame and the result slot is taken.
  assign step        = byte_valid_r && (!frm.last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !byte_valid_r || step;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_take) begin
      byte_valid_r <= 1'b1;
    end else if (step) begin
      byte_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && frm.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frm.last) begin
      result_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_status    = result_r.frame_status;
  assign out_ch.presence_code   = result_r.presence_code;
  assign out_ch.target_distance = result_r.target_distance;
  assign out_ch.signal_level    = result_r.signal_level;
  assign out_ch.in_zone         = result_r.in_zone;
  assign out_ch.range_changed   = result_r.range_changed;
  assign out_ch.motion_run      = result_r.motion_run;

  // Checks on the framing and result logic.
  `RFPD_ASSERT_NEXT(a_frame_end_gives_word, step && frm.last, out_valid_r)
  `RFPD_ASSERT_NEXT(a_bad_sum_flagged, step && frm.last && !frm.cksum_ok, result_r.frame_status == FRAME_CKS_ERR)
  `RFPD_ASSERT_SAME(a_err_fields_zero, out_valid_r && result_r.frame_status == FRAME_CKS_ERR, !result_r.in_zone && !result_r.range_changed && result_r.motion_run == 8'd0)
  `RFPD_ASSERT_SAME(a_range_needs_presence, out_valid_r && result_r.in_zone, result_r.presence_code != PRES_NONE)

endmodule

FILE: rtl/core/rfpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector configuration registers
// Holds the threshold, distance window and motion run length.
// ----------------------------------------------------------------------------
module rfpd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  rfpd_cfg_if.sink      cfg_ch,
  output rfpd_pkg::cfg_t cfg
);
  import rfpd_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken; an unknown index is ignored.
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signal_threshold  <= RST_SIG_THR;
      cfg_r.distance_min      <= RST_DIST_MIN;
      cfg_r.distance_max      <= RST_DIST_MAX;
      cfg_r.motion_run_needed <= RST_RUN_NEEDED;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_SIG_THR:    cfg_r.signal_threshold  <= cfg_ch.wdata;
        REG_DIST_MIN:   cfg_r.distance_min      <= cfg_ch.wdata;
        REG_DIST_MAX:   cfg_r.distance_max      <= cfg_ch.wdata;
        REG_RUN_NEEDED: cfg_r.motion_run_needed <= cfg_ch.wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/rfpd_framer.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector framer
// Hunts for the header, tracks the byte position, sums the frame and
// captures the presence, distance and signal fields.
// ----------------------------------------------------------------------------
module rfpd_framer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output rfpd_pkg::frame_t frm
);
  import rfpd_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  presence_r;
  logic [15:0] distance_r;
  logic [15:0] signal_r;
  logic [7:0]  sum_add;

  assign sum_add = sum_r + rx_byte;

  // Position and checksum sequencing.
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (pos_r >= POS_CKSUM) begin
      pos_nxt = POS_HUNT;
    end else begin
      case (pos_r)
        POS_HUNT: begin
          if (rx_byte == HDR_FIRST) begin
            sum_nxt = rx_byte;
            pos_nxt = POS_HDR2;
          end
        end
        POS_HDR2: begin
          if (rx_byte == HDR_SECOND) begin
            sum_nxt = sum_add;
            pos_nxt = POS_BODY;
          end else begin
            pos_nxt = POS_HUNT;
          end
        end
        default: begin
          sum_nxt = sum_add;
          pos_nxt = pos_r + 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Field capture from fixed frame positions.
  always_ff @(posedge clk) begin
    if (step) begin
      case (pos_r)
        POS_PRESENCE: presence_r        <= rx_byte;
        POS_DIST_HI:  distance_r[15:8]  <= rx_byte;
        POS_DIST_LO:  distance_r[7:0]   <= rx_byte;
        POS_SIG_HI:   signal_r[15:8]    <= rx_byte;
        POS_SIG_LO:   signal_r[7:0]     <= rx_byte;
        default: ;
      endcase
    end
  end

  assign frm.last     = (pos_r >= POS_CKSUM);
  assign frm.cksum_ok = (rx_byte == sum_r);
  assign frm.presence = presence_r;
  assign frm.distance = distance_r;
  assign frm.signal   = signal_r;

endmodule

FILE: rtl/core/rfpd_decider.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector decider
// Updates the motion run, makes the in-range decision and builds the result.
// ----------------------------------------------------------------------------
module rfpd_decider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rfpd_pkg::frame_t  frm,
  input  rfpd_pkg::cfg_t    cfg,
  output rfpd_pkg::result_t res
);
  import rfpd_pkg::*;

  logic [7:0]  motion_r, motion_nxt;
  logic        last_dec_r;
  logic        decision;
  logic        sig_ok;
  logic        dist_ok;
  logic        weak_ok;
  logic [19:0] sig_scaled;
  logic [19:0] thr_scaled;
  logic        good_frame;

  assign good_frame = step && frm.last && frm.cksum_ok;

  // Motion run: cleared on no presence, saturating count on motion or still presence; other codes hold it.
  always_comb begin
    motion_nxt = motion_r;
    if (frm.presence == PRES_NONE) begin
      motion_nxt = '0;
    end else if (frm.presence == PRES_MOTION || frm.presence == PRES_STILL) begin
      if (motion_r != RUN_MAX) begin
        motion_nxt = motion_r + 8'd1;
      end
    end
  end

  // Detection decision; the reduced path stands in for a 0.7 threshold factor.
  assign sig_scaled = 20'(frm.signal) * WEAK_SIG_MUL;
  assign thr_scaled = 20'(cfg.signal_threshold) * WEAK_THR_MUL;
  assign sig_ok     = (frm.signal >= cfg.signal_threshold);
  assign dist_ok    = (frm.distance >= cfg.distance_min) &&
                      (frm.distance <= cfg.distance_max);
  assign weak_ok    = (motion_nxt >= cfg.motion_run_needed) && (sig_scaled >= thr_scaled);
  assign decision   = (frm.presence != PRES_NONE) && dist_ok && (sig_ok || weak_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r   <= '0;
      last_dec_r <= 1'b0;
    end else if (good_frame) begin
      motion_r   <= motion_nxt;
      last_dec_r <= decision;
    end
  end

  // A checksum error gives a status word with all other fields zero.
  always_comb begin
    res = '0;
    if (frm.cksum_ok) begin
      res.frame_status    = FRAME_OK;
      res.presence_code   = frm.presence;
      res.target_distance = frm.distance;
      res.signal_level    = frm.signal;
      res.in_zone         = decision;
      res.range_changed   = decision ^ last_dec_r;
      res.motion_run      = motion_nxt;
    end else begin
      res.frame_status    = FRAME_CKS_ERR;
    end
  end

endmodule

FILE: sim/radar_frame_presence_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// Radar frame presence detector testbench
// Feeds serial bytes into the block: directed frames, register extremes,
// result back-pressure, a long motion run with a clear, then random
// streams of good, corrupt and truncated frames mixed with line noise. A
// predictor built into the testbench follows every accepted byte. Each result
// word is checked field by field against the oldest predicted frame result.
// ----------------------------------------------------------------------------
module radar_frame_presence_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfpd_pkg::*;

  localparam int FRAME_BYTES   = POS_CKSUM + 1;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;

  rfpd_in_if  in_ch ();
  rfpd_out_if out_ch ();
  rfpd_cfg_if cfg_ch ();

  radar_frame_presence_detector_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: framer position, checksum and the fields held so far.
  logic [4:0]  frame_pos   = POS_HUNT;
  logic [7:0]  frame_sum   = '0;
  logic [7:0]  held_pres   = '0;
  logic [15:0] held_dist   = '0;
  logic [15:0] held_sig    = '0;
  logic [7:0]  motion_run  = '0;
  logic        prev_in_zone = 1'b0;
  cfg_t        regs = '{RST_SIG_THR, RST_DIST_MIN, RST_DIST_MAX, RST_RUN_NEEDED};

  result_t     frame_results [$];
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned hold_off_cycles = 0;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Overall time limit.
  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  // Follow one accepted byte through the framer and queue any frame result.
  task automatic track_byte(input logic [7:0] b);
    result_t res;
    logic    sig_ok;
    logic    dist_ok;
    logic    weak_ok;
    logic    decision;
    if (frame_pos == POS_HUNT) begin
      if (b == HDR_FIRST) begin
        frame_sum = b;
        frame_pos = POS_HDR2;
      end
    end else if (frame_pos == POS_HDR2) begin
      // Anything but the second header byte drops back to the hunt.
      if (b == HDR_SECOND) begin
        frame_sum = frame_sum + b;
        frame_pos = POS_BODY;
      end else begin
        frame_pos = POS_HUNT;
      end
    end else if (frame_pos != POS_CKSUM) begin
      frame_sum = frame_sum + b;
      case (frame_pos)
        POS_PRESENCE: held_pres = b;
        POS_DIST_HI:  held_dist[15:8] = b;
        POS_DIST_LO:  held_dist[7:0] = b;
        POS_SIG_HI:   held_sig[15:8] = b;
        POS_SIG_LO:   held_sig[7:0] = b;
        default: ;
      endcase
      frame_pos = frame_pos + 1'b1;
    end else begin
      frame_pos = POS_HUNT;
      res = '0;
      if (b != frame_sum) begin
        res.frame_status = FRAME_CKS_ERR;
      end else begin
        // The motion run clears on no presence and saturates at its ceiling.
        if (held_pres == PRES_NONE) begin
          motion_run = '0;
        end else if ((held_pres == PRES_MOTION || held_pres == PRES_STILL) &&
                     motion_run != RUN_MAX) begin
          motion_run = motion_run + 1'b1;
        end
        sig_ok  = held_sig >= regs.signal_threshold;
        dist_ok = held_dist >= regs.distance_min && held_dist <= regs.distance_max;
        weak_ok = motion_run >= regs.motion_run_needed &&
                  32'(held_sig) * 32'(WEAK_SIG_MUL) >=
                  32'(regs.signal_threshold) * 32'(WEAK_THR_MUL);
        decision = held_pres != PRES_NONE && dist_ok && (sig_ok || weak_ok);
        res.frame_status    = FRAME_OK;
        res.presence_code   = held_pres;
        res.target_distance = held_dist;
        res.signal_level    = held_sig;
        res.in_zone         = decision;
        res.range_changed   = decision != prev_in_zone;
        res.motion_run      = motion_run;
        prev_in_zone = decision;
      end
      frame_results.push_back(res);
    end
  endtask

  // Offer one byte, with an optional idle burst first, until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    track_byte(b);
  endtask

  // Send a whole frame with random filler bytes around the decoded fields.
  task automatic send_frame(input logic [7:0] pres, input logic [15:0] tgt_dist,
                            input logic [15:0] sig, input bit bad_sum);
    logic [7:0] fr [FRAME_BYTES];
    logic [7:0] sum;
    sum = '0;
    for (int k = 0; k < FRAME_BYTES; k++) fr[k] = 8'($urandom);
    fr[0]            = HDR_FIRST;
    fr[1]            = HDR_SECOND;
    fr[POS_PRESENCE] = pres;
    fr[POS_DIST_HI]  = tgt_dist[15:8];
    fr[POS_DIST_LO]  = tgt_dist[7:0];
    fr[POS_SIG_HI]   = sig[15:8];
    fr[POS_SIG_LO]   = sig[7:0];
    for (int k = 0; k < POS_CKSUM; k++) sum = sum + fr[k];
    fr[POS_CKSUM] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
    foreach (fr[k]) send_byte(fr[k]);
  endtask

  // Frame with fields aimed at the current thresholds and window edges.
  task automatic send_random_frame();
    logic [7:0]  pres;
    logic [15:0] tgt_dist;
    logic [15:0] sig;
    int unsigned pick;
    int unsigned weak_edge;
    pick = $urandom_range(0, 9);
    if (pick < 2) pres = PRES_NONE;
    else if (pick < 5) pres = PRES_MOTION;
    else if (pick < 8) pres = PRES_STILL;
    else pres = 8'($urandom);
    case ($urandom_range(0, 3))
      0: tgt_dist = 16'($urandom);
      1: tgt_dist = regs.distance_min + 16'($urandom_range(0, 2)) - 16'd1;
      2: tgt_dist = regs.distance_max + 16'($urandom_range(0, 2)) - 16'd1;
      default: begin
        if (regs.distance_min <= regs.distance_max) begin
          tgt_dist = regs.distance_min +
                     16'($urandom_range(0, regs.distance_max - regs.distance_min));
        end else begin
          tgt_dist = 16'($urandom);
        end
      end
    endcase
    weak_edge = (32'(regs.signal_threshold) * WEAK_THR_MUL + WEAK_SIG_MUL - 1) /
                WEAK_SIG_MUL;
    case ($urandom_range(0, 3))
      0: sig = 16'($urandom);
      1: sig = regs.signal_threshold + 16'($urandom_range(0, 2)) - 16'd1;
      2: sig = 16'(weak_edge + $urandom_range(0, 2) - 1);
      default: sig = 16'($urandom_range(0, 2 * regs.signal_threshold));
    endcase
    send_frame(pres, tgt_dist, sig, $urandom_range(0, 9) == 0);
  endtask

  // Line noise, biased towards header bytes and broken headers.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 2) == 0) begin
        b = 8'($urandom);
        if (b == HDR_SECOND) b = HDR_FIRST;
        send_byte(HDR_FIRST);
        send_byte(b);
      end else begin
        send_byte($urandom_range(0, 1) ? HDR_FIRST : 8'($urandom));
      end
    end
  endtask

  // Push the framer back to the hunt with zero bytes, then wait for quiet.
  task automatic finish_phase();
    repeat (FRAME_BYTES - 1) send_byte(8'h00);
    in_ch.valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; only called while the block is idle.
  task automatic write_config(input logic [15:0] thr, input logic [15:0] dmin,
                              input logic [15:0] dmax, input logic [7:0] run_needed);
    logic [7:0]  ids [4];
    logic [15:0] vals [4];
    ids  = '{REG_SIG_THR, REG_DIST_MIN, REG_DIST_MAX, REG_RUN_NEEDED};
    vals = '{thr, dmin, dmax, {8'h00, run_needed}};
    cfg_ch.valid <= 1'b1;
    foreach (ids[k]) begin
      cfg_ch.idx   <= ids[k];
      cfg_ch.wdata <= vals[k];
      do @(posedge clk); while (!cfg_ch.ready);
      case (ids[k])
        REG_SIG_THR:    regs.signal_threshold = vals[k];
        REG_DIST_MIN:   regs.distance_min = vals[k];
        REG_DIST_MAX:   regs.distance_max = vals[k];
        REG_RUN_NEEDED: regs.motion_run_needed = vals[k][7:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Header hunting and the decision paths under the reset configuration.
  task automatic test_hunt_and_decisions();
    // A repeated first header byte is dropped, so the following 0xA5 is too.
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(8'h00);
    send_frame(PRES_MOTION, 16'd50, 16'd200, 1'b0);
    send_frame(PRES_NONE, 16'd50, 16'd200, 1'b0);
    // Unknown presence code, distance and signal exactly on their limits.
    send_frame(8'd3, RST_DIST_MIN, RST_SIG_THR, 1'b0);
    send_frame(PRES_MOTION, 16'd60, 16'd300, 1'b1);
    // Reduced threshold path: only the third still frame reaches the run.
    repeat (3) send_frame(PRES_STILL, RST_DIST_MAX, 16'd105, 1'b0);
    send_frame(PRES_MOTION, 16'd80, 16'd104, 1'b0);
    send_frame(PRES_MOTION, RST_DIST_MAX + 16'd1, 16'd500, 1'b0);
    send_frame(PRES_MOTION, RST_DIST_MIN - 16'd1, 16'd500, 1'b0);
    finish_phase();
  endtask

  // Register and field extremes, including an empty distance window.
  task automatic test_register_extremes();
    write_config(16'h0000, 16'h0000, 16'hFFFF, 8'h00);
    send_frame(PRES_STILL, 16'h0000, 16'h0000, 1'b0);
    send_frame(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(PRES_NONE, 16'hFFFF, 16'h0000, 1'b0);
    finish_phase();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_frame(PRES_MOTION, 16'hFFFF, 16'hFFFF, 1'b0);
    send_frame(PRES_MOTION, 16'hFFFF, 16'hFFFE, 1'b0);
    send_frame(PRES_MOTION, 16'hFFFE, 16'hFFFF, 1'b0);
    finish_phase();
    write_config(16'd0, 16'd200, 16'd100, 8'd0);
    send_frame(PRES_MOTION, 16'd150, 16'hFFFF, 1'b0);
    send_frame(PRES_STILL, 16'd200, 16'hFFFF, 1'b0);
    finish_phase();
  endtask

  // Results held back long enough for the block to stall its input.
  task automatic test_backpressure();
    write_config(RST_SIG_THR, RST_DIST_MIN, RST_DIST_MAX, RST_RUN_NEEDED);
    hold_off_cycles = 200;
    repeat (6) send_random_frame();
    finish_phase();
  endtask

  // A motion run that passes the run length needed, then a clear.
  task automatic test_motion_run();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_config(16'd1000, 16'h0000, 16'hFFFF, 8'd6);
    for (int k = 0; k < 8; k++) begin
      send_frame(k[0] ? PRES_MOTION : PRES_STILL, 16'($urandom),
                 16'($urandom_range(650, 1050)), 1'b0);
    end
    send_frame(PRES_NONE, 16'd100, 16'd2000, 1'b0);
    send_frame(PRES_MOTION, 16'd100, 16'd800, 1'b0);
    finish_phase();
  endtask

  // Random streams over several random configurations.
  task automatic test_random_stream();
    int unsigned start;
    for (int phase = 0; phase < 3; phase++) begin
      write_config($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400)),
                   16'($urandom_range(0, 100)), 16'($urandom_range(50, 400)),
                   $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6)));
      src_idle_on  = phase != 2;
      sink_idle_on = phase != 2;
      if (phase == 1) hold_off_cycles = 150;
      start = bytes_sent;
      while (bytes_sent - start < 100) begin
        // Switch idling on and off now and then, except in the last phase.
        if (phase != 2 && $urandom_range(0, 15) == 0) src_idle_on = !src_idle_on;
        if (phase != 2 && $urandom_range(0, 15) == 0) sink_idle_on = !sink_idle_on;
        case ($urandom_range(0, 9))
          0: send_noise();
          1: begin
            // Truncated frame: its bytes run on into whatever follows.
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
          end
          default: send_random_frame();
        endcase
      end
      finish_phase();
    end
  endtask

  // Ready on the result channel: random stalls and requested long hold-offs.
  initial begin : result_ready
    int unsigned n;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest predicted one.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_results.size() == 0) begin
        $error("result word with no frame result predicted");
        error_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("frame_status", want.frame_status, out_ch.frame_status);
        check_field("presence_code", want.presence_code, out_ch.presence_code);
        check_field("target_distance", want.target_distance, out_ch.target_distance);
        check_field("signal_level", want.signal_level, out_ch.signal_level);
        check_field("in_zone", want.in_zone, out_ch.in_zone);
        check_field("range_changed", want.range_changed, out_ch.range_changed);
        check_field("motion_run", want.motion_run, out_ch.motion_run);
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.idx    <= '0;
    cfg_ch.wdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hunt_and_decisions();
    test_backpressure();
    test_register_extremes();
    test_motion_run();
    test_random_stream();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
